>>> src/tpos_pkg.sv
package tpos_pkg;

    localparam int NUM_QUEUES = 8;
    localparam int TOKEN_BITS = 24;

    localparam int SLOT_AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SLOT_CW = SLOT_AW + 1;
    localparam int PROD_W  = 24;
    localparam int WIDE_W  = ((TOKEN_BITS > PROD_W) ? TOKEN_BITS : PROD_W) + 1;

    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DROP   = 3'd1,
        ACT_HEAD   = 3'd2,
        ACT_SELECT = 3'd3,
        ACT_CREATE = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  queue_slot;
        logic [15:0] packet_length;
        logic [7:0]  queue_priority;
        logic [7:0]  receive_rate;
        logic [7:0]  send_rate;
        logic [23:0] token_cap;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  granted_slot;
        logic [15:0] granted_length;
    } out_item_t;

    typedef struct packed {
        logic [15:0]           waiting;
        logic [TOKEN_BITS-1:0] tokens;
        logic [15:0]           head_length;
        logic [7:0]            priority_lvl;
        logic [7:0]            receive_rate;
        logic [7:0]            send_rate;
        logic [TOKEN_BITS-1:0] token_cap;
    } entry_t;

    typedef struct packed {
        logic              update;
        logic              winner;
        logic [15:0]       len;
        logic [PROD_W-1:0] cost;
    } alu_ctl_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RMW  = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_COST = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

>>> src/tpos_ram.sv
module tpos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tpos_alu.sv
module tpos_alu (
    input  tpos_pkg::alu_ctl_t ctl,
    input  tpos_pkg::in_item_t item,
    input  tpos_pkg::entry_t   ent_in,
    output tpos_pkg::entry_t   ent_out,
    output logic               tokens_ok
);
    import tpos_pkg::*;

    logic [PROD_W-1:0] need;
    logic [PROD_W-1:0] gain;
    logic [WIDE_W-1:0] tok_w;
    logic [WIDE_W-1:0] paid;
    logic [WIDE_W-1:0] sum;
    logic [WIDE_W-1:0] cap_w;
    logic [WIDE_W-1:0] capped;
    logic [WIDE_W-1:0] new_cap;

    assign need      = PROD_W'(ent_in.head_length) * PROD_W'(ent_in.send_rate);
    assign tok_w     = WIDE_W'(ent_in.tokens);
    assign tokens_ok = tok_w >= WIDE_W'(need);

    // winner pays first (floored), then every slot earns, capped
    assign paid   = !ctl.winner ? tok_w :
                    (tok_w >= WIDE_W'(ctl.cost)) ? tok_w - WIDE_W'(ctl.cost) : '0;
    assign gain   = PROD_W'(ctl.len) * PROD_W'(ent_in.receive_rate);
    assign sum    = paid + WIDE_W'(gain);
    assign cap_w  = WIDE_W'(ent_in.token_cap);
    assign capped = (sum > cap_w) ? cap_w : sum;

    assign new_cap = (WIDE_W'(item.token_cap) > WIDE_W'(TOKEN_MAX)) ?
                     WIDE_W'(TOKEN_MAX) : WIDE_W'(item.token_cap);

    always_comb begin
        ent_out = ent_in;
        if (ctl.update) begin
            ent_out.tokens = TOKEN_BITS'(capped);
            if (ctl.winner) begin
                ent_out.waiting = ent_in.waiting - 16'd1;
            end
        end else begin
            unique case (item.action)
                ACT_INSERT: begin
                    if (ent_in.waiting != 16'hFFFF) begin
                        ent_out.waiting = ent_in.waiting + 16'd1;
                    end
                end
                ACT_DROP: begin
                    if (ent_in.waiting != 16'd0) begin
                        ent_out.waiting = ent_in.waiting - 16'd1;
                    end
                end
                ACT_HEAD: ent_out.head_length = item.packet_length;
                ACT_CREATE: begin
                    ent_out.waiting      = '0;
                    ent_out.tokens       = '0;
                    ent_out.head_length  = '0;
                    ent_out.priority_lvl = item.queue_priority;
                    ent_out.receive_rate = item.receive_rate;
                    ent_out.send_rate    = item.send_rate;
                    ent_out.token_cap    = TOKEN_BITS'(new_cap);
                end
                default: ent_out = ent_in;
            endcase
        end
    end

endmodule

>>> src/token_priority_output_scheduler_core.sv
// Token-bucket gated strict-priority scheduler for one output port.
// Input channel s_valid/s_ready/s_data carries one command item: insert,
// drop, set head length, create queue, or select. Only select returns an
// item on m_valid/m_ready/m_data (granted, slot, head length).
// Per-slot entries live in one single-port-read RAM, one entry per slot; the
// valid and written flags per slot are registers. Insert, drop, set head and
// create are a read-modify-write: the entry is read on accept and written back
// in ST_RMW. Select: one scan pass reading one slot per cycle, a cost step to
// form the winner's cost, one update pass writing each valid slot's tokens back
// and a step to load the output register. With nothing waiting the update pass
// is skipped. The RAM port, one entry per cycle, sets the length of both passes.
// One item is worked on at a time; s_ready is high whenever the sequencer is
// idle.
// A result waiting in the output register does not block new commands; a
// select finding the register full with m_ready low holds until it frees.
// Reset (aresetn low, synchronous) clears per-slot valid and written flags,
// so every slot reads as all zero, and empties the output register.
module token_priority_output_scheduler_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tpos_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tpos_pkg::out_item_t   m_data
);
    import tpos_pkg::*;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    logic [SLOT_CW-1:0] cnt_reg, cnt_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [SLOT_AW-1:0] ev_idx_reg, ev_idx_next;
    logic               rd_live_reg, rd_live_next;
    logic               found_reg, found_next;
    logic               best_tk_reg, best_tk_next;
    logic [7:0]         best_pr_reg, best_pr_next;
    logic [SLOT_AW-1:0] best_idx_reg, best_idx_next;
    logic [15:0]        best_len_reg, best_len_next;
    logic [7:0]         best_sr_reg, best_sr_next;
    logic [PROD_W-1:0]  cost_reg, cost_next;
    logic [NUM_QUEUES-1:0] valid_reg, valid_next;
    logic [NUM_QUEUES-1:0] live_reg, live_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               re, we;
    logic [SLOT_AW-1:0] raddr, waddr;
    logic [$bits(entry_t)-1:0] rdata;
    entry_t             ent_rd, ent_wr;
    alu_ctl_t           ctl;
    logic               tk;
    logic               accept, slot_ok, cand, better;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign slot_ok = 32'(s_data.queue_slot) < NUM_QUEUES;
    assign ent_rd  = rd_live_reg ? entry_t'(rdata) : '0;

    assign ctl.update = (state_reg == ST_UPD);
    assign ctl.winner = (ev_idx_reg == best_idx_reg);
    assign ctl.len    = best_len_reg;
    assign ctl.cost   = cost_reg;

    tpos_alu u_alu (
        .ctl      (ctl),
        .item     (item_reg),
        .ent_in   (ent_rd),
        .ent_out  (ent_wr),
        .tokens_ok(tk)
    );

    tpos_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(NUM_QUEUES)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(ent_wr),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign cand   = ev_vld_reg && valid_reg[ev_idx_reg] && (ent_rd.waiting != 16'd0);
    assign better = !found_reg || (tk && !best_tk_reg) ||
                    ((tk == best_tk_reg) && (ent_rd.priority_lvl > best_pr_reg));

    always_comb begin
        re    = 1'b0;
        raddr = cnt_reg[SLOT_AW-1:0];
        if (state_reg == ST_IDLE) begin
            re    = accept;
            raddr = SLOT_AW'(s_data.queue_slot);
        end else if (state_reg == ST_SCAN || state_reg == ST_UPD) begin
            re = cnt_reg < SLOT_CW'(NUM_QUEUES);
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = ev_idx_reg;
        if (state_reg == ST_RMW) begin
            we    = 1'b1;
            waddr = SLOT_AW'(item_reg.queue_slot);
        end else if (state_reg == ST_UPD) begin
            we = ev_vld_reg && valid_reg[ev_idx_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        cnt_next      = cnt_reg;
        ev_vld_next   = 1'b0;
        ev_idx_next   = cnt_reg[SLOT_AW-1:0];
        rd_live_next  = re ? live_reg[raddr] : rd_live_reg;
        found_next    = found_reg;
        best_tk_next  = best_tk_reg;
        best_pr_next  = best_pr_reg;
        best_idx_next = best_idx_reg;
        best_len_next = best_len_reg;
        best_sr_next  = best_sr_reg;
        cost_next     = cost_reg;
        valid_next    = valid_reg;
        live_next     = live_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next = s_data;
                    unique case (s_data.action) inside
                        ACT_SELECT: begin
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                            found_next = 1'b0;
                        end
                        ACT_INSERT, ACT_DROP, ACT_HEAD, ACT_CREATE: begin
                            if (slot_ok) begin
                                state_next = ST_RMW;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RMW: begin
                live_next[SLOT_AW'(item_reg.queue_slot)] = 1'b1;
                if (item_reg.action == ACT_CREATE) begin
                    valid_next[SLOT_AW'(item_reg.queue_slot)] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (re) begin
                    cnt_next    = cnt_reg + 1'b1;
                    ev_vld_next = 1'b1;
                end
                if (cand && better) begin
                    found_next    = 1'b1;
                    best_tk_next  = tk;
                    best_pr_next  = ent_rd.priority_lvl;
                    best_idx_next = ev_idx_reg;
                    best_len_next = ent_rd.head_length;
                    best_sr_next  = ent_rd.send_rate;
                end
                if (ev_vld_reg && (32'(ev_idx_reg) == NUM_QUEUES - 1)) begin
                    state_next = ST_COST;
                end
            end
            ST_COST: begin
                cost_next  = PROD_W'(best_len_reg) * PROD_W'(best_sr_reg);
                cnt_next   = '0;
                state_next = found_reg ? ST_UPD : ST_OUT;
            end
            ST_UPD: begin
                if (re) begin
                    cnt_next    = cnt_reg + 1'b1;
                    ev_vld_next = 1'b1;
                end
                if (ev_vld_reg && (32'(ev_idx_reg) == NUM_QUEUES - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.granted         = found_reg;
                    m_data_next.granted_slot    = found_reg ? 3'(best_idx_reg) : 3'd0;
                    m_data_next.granted_length  = found_reg ? best_len_reg : 16'd0;
                    state_next                  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ev_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            ev_vld_reg  <= ev_vld_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        ev_idx_reg   <= ev_idx_next;
        rd_live_reg  <= rd_live_next;
        best_tk_reg  <= best_tk_next;
        best_pr_reg  <= best_pr_next;
        best_idx_reg <= best_idx_next;
        best_len_reg <= best_len_next;
        best_sr_reg  <= best_sr_next;
        cost_reg     <= cost_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside output state");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg != ST_IDLE))
        else $error("memory write while idle");

    a_winner_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COST && found_reg) |-> valid_reg[best_idx_reg])
        else $error("winner slot not valid");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.granted) |->
            (m_data_reg.granted_slot == 3'd0 && m_data_reg.granted_length == 16'd0))
        else $error("empty grant carries data");

endmodule
